@@ hw/rtl/dsa_pkg.sv @@
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants for the deduplicating slot allocator: result
// codes, stream field widths and the controller/datapath command and status
// bundles.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned S_DATA_W  = 72;  // 66 bits of fields, padded to bytes
  localparam int unsigned S_USER_W  = 1;
  localparam int unsigned M_DATA_W  = 16;  // 10-bit slot, padded to bytes
  localparam int unsigned M_USER_W  = STATUS_W;

  // operation codes carried in s_tuser
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_RESET    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND   = 3'd0,
    ST_STORED  = 3'd1,
    ST_FULL    = 3'd2,
    ST_INVALID = 3'd3,
    ST_RESET   = 3'd4
  } status_t;

  // where the result slot comes from
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_HIT  = 2'd1,
    RES_NEW  = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     load_key;
    logic     start_scan;
    logic     scan;
    logic     insert;
    logic     table_reset;
    logic     set_res;
    res_sel_t res_sel;
    status_t  res_status;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic op_reset;
    logic key_ok;
    logic hit;
    logic scan_done;
    logic full;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/dsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer for the slot allocator: takes one item, classifies it, clears the
// table on a reset item or scans it for a valid key, decides between hit,
// insert and fallback, then hands the result to the output register.
// ----------------------------------------------------------------------------
module dsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  dsa_pkg::sts_t sts,
  output dsa_pkg::cmd_t cmd
);
  import dsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_sel    = RES_ZERO;
    cmd.res_status = ST_FOUND;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_key = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.op_reset) begin
          cmd.table_reset = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_status  = ST_RESET;
          state_next      = S_EMIT;
        end else if (!sts.key_ok) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_INVALID;
          state_next     = S_EMIT;
        end else begin
          cmd.start_scan = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.set_res    = 1'b1;
          cmd.res_sel    = RES_HIT;
          cmd.res_status = ST_FOUND;
          state_next     = S_EMIT;
        end else if (sts.scan_done) begin
          cmd.set_res = 1'b1;
          if (sts.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.insert     = 1'b1;
            cmd.res_sel    = RES_NEW;
            cmd.res_status = ST_STORED;
          end
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a match ends the scan right away
  a_hit_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.hit) |=> (state == S_EMIT))
    else $error("scan did not stop on a hit");

  // a new item is only taken after the previous result has been handed over
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (state == S_IDLE))
    else $error("emit did not return to idle");

endmodule

@@ hw/rtl/dsa_path.sv @@
// ----------------------------------------------------------------------------
// dsa_path
// Datapath of the slot allocator: key registers, the key memory with one
// registered read port, the scan counter and compare stage, the free
// pointer and the output register.
// ----------------------------------------------------------------------------
module dsa_path #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [dsa_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [dsa_pkg::S_USER_W-1:0]   s_tuser,
  input  dsa_pkg::cmd_t                  cmd,
  output dsa_pkg::sts_t                  sts,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dsa_pkg::M_DATA_W-1:0]   m_tdata,
  output logic [dsa_pkg::M_USER_W-1:0]   m_tuser
);
  import dsa_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = 2 * KEY_W;

  // item registers
  logic              key_op;
  logic              key_vok;
  logic              key_sok;
  logic [KEY_W-1:0]  key_view;
  logic [KEY_W-1:0]  key_samp;

  // table state; slots in use are slot 0 (if slot0_used) and 1 .. next_free-1
  logic [EW-1:0]     mem [TABLE_DEPTH];
  logic [NW-1:0]     next_free;
  logic              slot0_used;

  // scan
  logic [NW-1:0]     scan_idx;
  logic              rd_issue;
  logic [EW-1:0]     mem_q;
  logic              cmp_vld;
  logic [IW-1:0]     cmp_idx;
  logic              match;

  // result
  logic [SLOT_W-1:0] res_slot;
  status_t           res_status;

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_op   <= s_tuser[0];
      key_view <= s_tdata[KEY_W-1:0];
      key_vok  <= s_tdata[KEY_W];
      key_samp <= s_tdata[2*KEY_W:KEY_W+1];
      key_sok  <= s_tdata[2*KEY_W+1];
    end
  end

  assign rd_issue = cmd.scan && (scan_idx < next_free);
  assign match    = cmp_vld && (mem_q == {key_samp, key_view});

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      mem_q <= mem[scan_idx[IW-1:0]];
    end
    if (cmd.insert) begin
      mem[next_free[IW-1:0]] <= {key_samp, key_view};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free  <= '0;
      slot0_used <= 1'b0;
      cmp_vld    <= 1'b0;
      scan_idx   <= '0;
    end else begin
      if (cmd.table_reset) begin
        next_free <= NW'(1);
      end else if (cmd.insert) begin
        next_free <= next_free + NW'(1);
        if (next_free == '0) begin
          slot0_used <= 1'b1;
        end
      end
      if (cmd.start_scan) begin
        scan_idx <= slot0_used ? '0 : NW'(1);
        cmp_vld  <= 1'b0;
      end else begin
        cmp_vld <= rd_issue;
        if (rd_issue) begin
          scan_idx <= scan_idx + NW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      cmp_idx <= scan_idx[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      case (cmd.res_sel)
        RES_HIT:  res_slot <= SLOT_W'(cmp_idx);
        RES_NEW:  res_slot <= SLOT_W'(next_free);
        default:  res_slot <= '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= M_DATA_W'(res_slot);
      m_tuser <= res_status;
    end
  end

  assign sts.op_reset  = (key_op == OP_RESET);
  assign sts.key_ok    = key_vok && key_sok;
  assign sts.hit       = match;
  assign sts.scan_done = !rd_issue && !cmp_vld;
  assign sts.full      = (next_free >= NW'(TABLE_DEPTH));
  assign sts.out_free  = !m_tvalid || m_tready;

  a_free_in_range: assert property (@(posedge clk) disable iff (rst)
    next_free <= NW'(TABLE_DEPTH))
    else $error("free pointer ran past the table");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !sts.full)
    else $error("insert into a full table");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwrote one not yet taken");

  a_slot0_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(slot0_used) |-> slot0_used)
    else $error("slot 0 lost its key");

endmodule

@@ hw/rtl/dedup_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// dedup_slot_allocator_unit
// Lookup-or-insert slot table for (view, sampler) key pairs: returns the
// slot of a stored pair, stores a new pair at the next free slot, or falls
// back to slot 0.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit first)                     | tuser
//  ---------+-----+-------------------------------------------+--------------
//  s_*      | in  | view_handle, view_ok, sampler_handle,     | operation
//           |     | sampler_ok, zero pad to 72                |
//  m_*      | out | slot, zero pad to 16                      | status
//
//  One item at a time: the next item is taken once the previous result has
//  moved to the output register. Reset and invalid-key items skip the scan; a
//  register item scans the occupied slots until a hit or the last one.
//  rst clears the table at once (used slots and free pointer); no clearing pass.
//  A stalled result holds the output register; the next item is still taken,
//  and its result waits in the result register until the output one is free.
// ----------------------------------------------------------------------------
module dedup_slot_allocator_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // view_handle[31:0], view_ok[32], sampler_handle[64:33], sampler_ok[65]
  input  logic [dsa_pkg::S_DATA_W-1:0]  s_tdata,
  // operation[0]
  input  logic [dsa_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // slot[9:0]
  output logic [dsa_pkg::M_DATA_W-1:0]  m_tdata,
  // status[2:0]
  output logic [dsa_pkg::M_USER_W-1:0]  m_tuser
);
  import dsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsa_path #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_path (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of dedup_slot_allocator_unit. Register, reset and invalid
// key items are driven with random gaps and back-pressure. Each accepted item
// runs through a local slot table model, and every returned slot and status
// is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import dsa_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HIST_MAX    = 24;

  typedef struct {
    logic              op;
    logic [KEY_W-1:0]  view;
    logic              view_ok;
    logic [KEY_W-1:0]  sampler;
    logic              sampler_ok;
  } key_req_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } slot_ans_t;

  logic                clk;
  logic                rst        = 1'b1;
  logic                s_tvalid   = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata    = '0;
  logic [S_USER_W-1:0] s_tuser    = '0;
  logic                m_tvalid;
  logic                m_tready   = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  // slot table model
  logic [KEY_W-1:0] view_tab [DEPTH];
  logic [KEY_W-1:0] samp_tab [DEPTH];
  bit               slot_busy [DEPTH];
  int unsigned      next_slot = 0;

  key_req_t    pending_reqs[$];
  key_req_t    recent_keys[$];
  key_req_t    on_bus;
  slot_ans_t   slot_answers[$];
  int unsigned send_idle_pct  = 6;
  int unsigned recv_stall_pct = 85;
  int unsigned mismatches     = 0;
  int unsigned stall_cycles   = 0;

  dedup_slot_allocator_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic slot_ans_t lookup_or_insert(key_req_t r);
    slot_ans_t a;
    a.slot   = '0;
    a.status = ST_RESET;
    if (r.op == OP_RESET) begin
      // slot 0 keeps its key and its used bit
      for (int i = 1; i < DEPTH; i++) slot_busy[i] = 1'b0;
      next_slot = 1;
      return a;
    end
    if (!r.view_ok || !r.sampler_ok) begin
      a.status = ST_INVALID;
      return a;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_busy[i] && view_tab[i] == r.view && samp_tab[i] == r.sampler) begin
        a.slot   = SLOT_W'(i);
        a.status = ST_FOUND;
        return a;
      end
    end
    if (next_slot >= DEPTH) begin
      a.status = ST_FULL;
      return a;
    end
    view_tab[next_slot]  = r.view;
    samp_tab[next_slot]  = r.sampler;
    slot_busy[next_slot] = 1'b1;
    a.slot   = SLOT_W'(next_slot);
    a.status = ST_STORED;
    next_slot++;
    return a;
  endfunction

  function automatic key_req_t make_req(logic op, logic [KEY_W-1:0] view, logic vok,
                                        logic [KEY_W-1:0] samp, logic sok);
    key_req_t r;
    r.op         = op;
    r.view       = view;
    r.view_ok    = vok;
    r.sampler    = samp;
    r.sampler_ok = sok;
    return r;
  endfunction

  // mostly repeats and fresh pairs, with some resets and invalid keys
  function key_req_t next_random_req();
    key_req_t    r;
    int unsigned roll;
    roll = $urandom_range(99);
    r = make_req(OP_REGISTER, $urandom(), 1'b1, $urandom(), 1'b1);
    if (roll < 7) begin
      r.op         = OP_RESET;
      r.view_ok    = $urandom_range(1);
      r.sampler_ok = $urandom_range(1);
    end else if (roll < 15) begin
      r.view_ok    = $urandom_range(1);
      r.sampler_ok = r.view_ok ? 1'b0 : 1'(($urandom_range(1)));
    end else if (roll < 55 && recent_keys.size() > 0) begin
      r = recent_keys[$urandom_range(recent_keys.size() - 1)];
    end else begin
      recent_keys.push_back(r);
      if (recent_keys.size() > HIST_MAX) void'(recent_keys.pop_front());
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (s_tvalid && s_tready)
        slot_answers.push_back(lookup_or_insert(on_bus));
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, on_bus.sampler_ok, on_bus.sampler, on_bus.view_ok, on_bus.view};
          s_tuser  <= on_bus.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    slot_ans_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (slot_answers.size() == 0) begin
        report_mismatch("unexpected item, slot", 0, m_tdata);
      end else begin
        want = slot_answers.pop_front();
        if (m_tdata !== M_DATA_W'(want.slot))
          report_mismatch("slot", want.slot, m_tdata);
        if (m_tuser !== want.status)
          report_mismatch("status", want.status, m_tuser);
      end
    end
  end

  // watchdog: no item moving on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    bit reset_first;
    reset_first = $urandom_range(1);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: the seed decides whether slot 0 ever gets a key
    if (reset_first)
      pending_reqs.push_back(make_req(OP_RESET, '0, 1'b0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_REGISTER, '0, 1'b1, '0, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '0, 1'b1, '0, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '1, 1'b1, '1, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '1, 1'b1, '0, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '0, 1'b1, '1, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '1, 1'b1, '1, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '1, 1'b0, '1, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '1, 1'b1, '1, 1'b0));
    pending_reqs.push_back(make_req(OP_REGISTER, '0, 1'b0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_RESET, '1, 1'b1, '1, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '0, 1'b1, '0, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '1, 1'b1, '1, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, '1, 1'b1, '1, 1'b1));
    pending_reqs.push_back(make_req(OP_RESET, '0, 1'b0, '0, 1'b0));
    pending_reqs.push_back(make_req(OP_REGISTER, 32'hAAAA_AAAA, 1'b1, 32'h5555_5555, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA, 1'b1));
    pending_reqs.push_back(make_req(OP_REGISTER, 32'hAAAA_AAAA, 1'b1, 32'h5555_5555, 1'b1));
    for (int n = 0; n < 200; n++) pending_reqs.push_back(next_random_req());
    while (pending_reqs.size() > 0 || s_tvalid) @(negedge clk);

    send_idle_pct  = 85;
    recv_stall_pct = 6;
    for (int n = 0; n < 190; n++) pending_reqs.push_back(next_random_req());
    while (pending_reqs.size() > 0 || s_tvalid) @(negedge clk);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 172; n++) pending_reqs.push_back(next_random_req());

    while (pending_reqs.size() > 0 || s_tvalid || slot_answers.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && slot_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_ctrl.sv
hw/rtl/dsa_path.sv
hw/rtl/dedup_slot_allocator_unit.sv
sim/tb.sv
